[hw/rtl/polyline_length_accumulator_defines.svh]
// Assertion macros shared by the polyline length accumulator RTL.
// Define ASSERT_OFF to compile every check away.
`ifndef POLYLINE_LENGTH_ACCUMULATOR_DEFINES_SVH
`define POLYLINE_LENGTH_ACCUMULATOR_DEFINES_SVH
`ifndef ASSERT_OFF
`define PLA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define PLA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define PLA_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define PLA_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

[hw/rtl/pll_pkg.sv]
package pll_pkg;

    // Sequencer states of the accumulator.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQX,
        ST_SQY,
        ST_SUM,
        ST_ROOT,
        ST_ACC
    } t_state;

    // Status of the square-root unit as seen by the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } t_sqrt_stat;

endpackage

[hw/rtl/pll_isqrt.sv]
`include "polyline_length_accumulator_defines.svh"

// Digit-by-digit integer square root, one result bit per cycle.
module pll_isqrt
    import pll_pkg::*;
#(
    parameter int ROOT_W = 25
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [2*ROOT_W-2:0]   i_radicand,
    output logic [ROOT_W-1:0]     o_root,
    output t_sqrt_stat            o_stat
);

    localparam int RAD_W = 2 * ROOT_W;
    localparam int REM_W = ROOT_W + 2;
    localparam int CNT_W = $clog2(ROOT_W);

    logic [RAD_W-1:0]  r_rad;
    logic [REM_W-1:0]  r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic              take;

    // Bring down the next two radicand bits and try appending a one to the root.
    always_comb begin
        rem_sh = {r_rem[REM_W-3:0], r_rad[RAD_W-1 -: 2]};
        trial  = {r_root, 2'b01};
        take   = (rem_sh >= trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == '0)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= {1'b0, i_radicand};
            r_rem  <= '0;
            r_root <= '0;
            r_cnt  <= CNT_W'(ROOT_W - 1);
        end else if (r_busy) begin
            r_rad  <= r_rad << 2;
            r_rem  <= take ? (rem_sh - trial) : rem_sh;
            r_root <= {r_root[ROOT_W-2:0], take};
            r_cnt  <= r_cnt - 1'b1;
        end
    end

    assign o_root      = r_root;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

    `PLA_ASSERT_NXT(a_start_busy, i_clk, i_rst_n, i_start, r_busy)
    `PLA_ASSERT_NXT(a_done_idle, i_clk, i_rst_n, r_done, !r_busy)
    `PLA_ASSERT_IMP(a_done_last, i_clk, i_rst_n, r_done, $past(r_cnt) == '0)

endmodule

[hw/rtl/polyline_length_accumulator.sv]
// Polyline length accumulator.
// Input stream: one point per item. s_axis_tdata carries x then y, signed
// fixed point; s_axis_tuser carries the new-chain and new-total flags. For a
// point that continues a chain, the block adds floor(sqrt(dx^2 + dy^2)) to a
// running total that saturates at its all-ones maximum.
// Output stream: one item per input item with the segment length, the total
// after this point and a flag that is set while the total is saturated.
// Sequence: a point that adds a segment steps from acceptance through the
// states SQX, SQY, SUM, ROOT and ACC before its result is registered. The
// square-root unit yields one root bit per cycle; squaring uses one shared
// multiplier, first for dx and then for dy. A point that adds no segment goes
// from IDLE straight to ACC.
// Flow: one point at a time; s_axis_tready is high only while the sequencer
// is idle, so no point is taken until the last one has left ACC. A finished
// result sits in an output register, so the next point is accepted while the
// receiver stalls; the sequencer then waits in its last step until the output
// register is free.
// Reset (synchronous, active low) clears the running total, forgets the
// previous point and drops any pending result.
module polyline_length_accumulator
    import pll_pkg::*;
#(
    parameter int COORD_WIDTH = 24,
    parameter int TOTAL_WIDTH = 48
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // Fields from the lowest bit: x_coord, y_coord, zero fill.
    input  logic [((2*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    // Fields from the lowest bit: new_chain, new_total.
    input  logic [1:0]            s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // Fields from the lowest bit: segment_length, total_length, zero fill.
    output logic [((COORD_WIDTH+2+TOTAL_WIDTH+7)/8)*8-1:0] m_axis_tdata,
    // Fields from the lowest bit: total_saturated.
    output logic [0:0]            m_axis_tuser
);

    `include "polyline_length_accumulator_defines.svh"

    localparam int CW     = COORD_WIDTH;
    localparam int TW     = TOTAL_WIDTH;
    localparam int ROOT_W = CW + 1;
    localparam int SEG_W  = CW + 2;
    localparam int SQ_W   = 2 * CW + 1;
    localparam int SUM_W  = ((TW > ROOT_W) ? TW : ROOT_W) + 1;

    t_state            r_state;
    t_state            n_state;

    logic [CW-1:0]     r_prev_x;
    logic [CW-1:0]     r_prev_y;
    logic              r_have_prev;
    logic [TW-1:0]     r_total;
    logic              r_do_seg;
    logic [CW-1:0]     r_dx;
    logic [CW-1:0]     r_dy;
    logic [2*CW-1:0]   r_sq_x;
    logic [2*CW-1:0]   r_sq_y;

    logic              r_m_valid;
    logic [ROOT_W-1:0] r_m_seg;
    logic [TW-1:0]     r_m_total;
    logic              r_m_sat;

    logic [CW-1:0]     in_x;
    logic [CW-1:0]     in_y;
    logic              in_new_chain;
    logic              in_new_total;
    logic              in_accept;
    logic signed [CW:0] diff_x;
    logic signed [CW:0] diff_y;
    logic signed [CW:0] neg_x;
    logic signed [CW:0] neg_y;
    logic [CW-1:0]     mag_x;
    logic [CW-1:0]     mag_y;

    logic              mul_sel_y;
    logic [CW-1:0]     mul_op;
    logic [2*CW-1:0]   mul_prod;
    logic              sq_start;
    logic [SQ_W-1:0]   sq_radicand;
    logic [ROOT_W-1:0] sq_root;
    t_sqrt_stat        sq_stat;

    logic              out_free;
    logic              acc_load;
    logic [ROOT_W-1:0] seg_val;
    logic [SUM_W-1:0]  acc_sum;
    logic              acc_ovf;
    logic [TW-1:0]     acc_next;

    // Input unpacking.
    assign in_x         = s_axis_tdata[CW-1:0];
    assign in_y         = s_axis_tdata[2*CW-1:CW];
    assign in_new_chain = s_axis_tuser[0];
    assign in_new_total = s_axis_tuser[1];
    assign in_accept    = s_axis_tvalid && s_axis_tready;

    // Absolute coordinate differences against the previous point, taken at
    // acceptance so the previous point can be replaced in the same cycle.
    always_comb begin
        diff_x = $signed({in_x[CW-1], in_x}) - $signed({r_prev_x[CW-1], r_prev_x});
        diff_y = $signed({in_y[CW-1], in_y}) - $signed({r_prev_y[CW-1], r_prev_y});
        neg_x  = -diff_x;
        neg_y  = -diff_y;
        mag_x  = diff_x[CW] ? neg_x[CW-1:0] : diff_x[CW-1:0];
        mag_y  = diff_y[CW] ? neg_y[CW-1:0] : diff_y[CW-1:0];
    end

    // Next-state logic of the sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = (r_have_prev && !in_new_chain) ? ST_SQX : ST_ACC;
                end
            end
            ST_SQX:  n_state = ST_SQY;
            ST_SQY:  n_state = ST_SUM;
            ST_SUM:  n_state = ST_ROOT;
            ST_ROOT: begin
                if (sq_stat.done) begin
                    n_state = ST_ACC;
                end
            end
            ST_ACC: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Output decode of the sequencer.
    always_comb begin
        s_axis_tready = 1'b0;
        mul_sel_y     = 1'b0;
        sq_start      = 1'b0;
        acc_load      = 1'b0;
        unique case (r_state)
            ST_IDLE: s_axis_tready = 1'b1;
            ST_SQX:  mul_sel_y     = 1'b0;
            ST_SQY:  mul_sel_y     = 1'b1;
            ST_SUM:  sq_start      = 1'b1;
            ST_ROOT: sq_start      = 1'b0;
            ST_ACC:  acc_load      = out_free;
            default: s_axis_tready = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // The one multiplier squares dx, then dy, on consecutive cycles.
    assign mul_op   = mul_sel_y ? r_dy : r_dx;
    assign mul_prod = mul_op * mul_op;

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_dx     <= mag_x;
            r_dy     <= mag_y;
            r_do_seg <= r_have_prev && !in_new_chain;
        end
        if (r_state == ST_SQX) begin
            r_sq_x <= mul_prod;
        end
        if (r_state == ST_SQY) begin
            r_sq_y <= mul_prod;
        end
    end

    assign sq_radicand = SQ_W'(r_sq_x) + SQ_W'(r_sq_y);

    pll_isqrt #(
        .ROOT_W (ROOT_W)
    ) u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (sq_start),
        .i_radicand (sq_radicand),
        .o_root     (sq_root),
        .o_stat     (sq_stat)
    );

    // Saturating accumulation of the segment length.
    assign out_free = !r_m_valid || m_axis_tready;
    assign seg_val  = r_do_seg ? sq_root : '0;
    assign acc_sum  = SUM_W'(r_total) + SUM_W'(seg_val);
    assign acc_ovf  = (acc_sum >> TW) != '0;
    assign acc_next = acc_ovf ? {TW{1'b1}} : acc_sum[TW-1:0];

    // Previous point and running total. A new-total point clears the total
    // at acceptance; the segment, if any, is then added to the cleared total.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_x    <= '0;
            r_prev_y    <= '0;
            r_have_prev <= 1'b0;
            r_total     <= '0;
        end else begin
            if (in_accept) begin
                r_prev_x    <= in_x;
                r_prev_y    <= in_y;
                r_have_prev <= 1'b1;
                if (in_new_total) begin
                    r_total <= '0;
                end
            end else if (acc_load) begin
                r_total <= acc_next;
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (acc_load) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc_load) begin
            r_m_seg   <= seg_val;
            r_m_total <= acc_next;
            r_m_sat   <= (acc_next == {TW{1'b1}});
        end
    end

    always_comb begin
        m_axis_tdata                     = '0;
        m_axis_tdata[SEG_W-1:0]          = SEG_W'(r_m_seg);
        m_axis_tdata[SEG_W+TW-1:SEG_W]   = r_m_total;
    end

    assign m_axis_tvalid   = r_m_valid;
    assign m_axis_tuser[0] = r_m_sat;

    `PLA_ASSERT_IMP(a_root_in_seq, i_clk, i_rst_n, sq_stat.done, r_state == ST_ROOT)
    `PLA_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, in_accept, !s_axis_tready)
    `PLA_ASSERT_IMP(a_sat_flag, i_clk, i_rst_n, r_m_valid,
                    r_m_sat == (r_m_total == {TW{1'b1}}))
    `PLA_ASSERT_IMP(a_no_seg_zero, i_clk, i_rst_n, acc_load && !r_do_seg, seg_val == '0)

endmodule
